// ===== design/bcd_arith_pkg.sv =====
// Package for the 16-digit BCD arithmetic unit: sizes, command codes and
// the per-digit adjust used by the binary to BCD converter.
// No dependencies.
package bcd_arith_pkg;

    // Number of decimal digits held and returned
    localparam int DIGITS    = 16;
    localparam int BCD_W     = 4 * DIGITS;
    localparam int OUT_BCD_W = 64;
    localparam int OPND_W    = 31;
    localparam int VAL_W     = 35;
    // Multiplier digit is four bits, one shift-add step per bit
    localparam int MUL_STEPS = 4;
    localparam int CNT_W     = $clog2(VAL_W + 1);
    localparam int MAX_DIGIT = 9;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_SHOW = 2'd1,
        CMD_ADD  = 2'd2,
        CMD_MUL  = 2'd3
    } t_cmd;

    // Double-dabble correction: a digit of five or more gets three added
    function automatic logic [3:0] dd_adjust(input logic [3:0] d);
        logic [3:0] r;
        r = (d >= 4'd5) ? d + 4'd3 : d;
        return r;
    endfunction

endpackage

// ===== design/bcd_digit_arithmetic_unit.sv =====
// Top level of the 16-digit BCD arithmetic unit: command sequencer,
// shift-add multiplier step and shift-add-3 binary to BCD converter.
// Depends on bcd_arith_pkg.
//
// One command is taken when start is high and busy is low; busy stays high
// until the result beat, which is shown for one cycle with o_done and cannot
// be held off. Show answers without raising busy. Load and add first form the
// binary value, then run 35 passes of the shared shift-add-3 stage that
// turns the 35-bit value into decimal digits, one bit per cycle. Multiply
// runs 4 shift-add steps over the multiplier digit on the same value
// register, then the 35 conversion passes. A multiplier digit above nine
// returns zero with o_status set, skipping the shift-add steps.
module bcd_digit_arithmetic_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          i_command,
    input  logic [bcd_arith_pkg::OPND_W-1:0]    i_operand_a,
    input  logic [bcd_arith_pkg::OPND_W-1:0]    i_operand_b,
    output logic                                o_done,
    output logic [bcd_arith_pkg::OUT_BCD_W-1:0] o_result_bcd,
    output logic [bcd_arith_pkg::VAL_W-1:0]     o_result_value,
    output logic                                o_status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_CONV
    } t_state;

    t_state                             r_state;
    bcd_arith_pkg::t_cmd                r_cmd;
    logic [bcd_arith_pkg::CNT_W-1:0]    r_cnt;
    logic [3:0]                         r_mul_b;
    logic [bcd_arith_pkg::OPND_W-1:0]   r_opnd;
    logic [bcd_arith_pkg::VAL_W-1:0]    r_bin;
    logic [bcd_arith_pkg::BCD_W-1:0]    r_bcd;
    logic                               r_status;
    logic [bcd_arith_pkg::BCD_W-1:0]    r_stored_bcd;
    logic [bcd_arith_pkg::OPND_W-1:0]   r_stored_val;
    logic                               r_done;
    logic [bcd_arith_pkg::OUT_BCD_W-1:0] r_res_bcd;
    logic [bcd_arith_pkg::VAL_W-1:0]    r_res_val;
    logic                               r_res_status;

    logic [bcd_arith_pkg::BCD_W-1:0]    n_adj;
    logic [bcd_arith_pkg::BCD_W-1:0]    n_bcd;
    logic [bcd_arith_pkg::VAL_W-1:0]    n_mul;
    bcd_arith_pkg::t_cmd                n_cmd;

    assign n_cmd = bcd_arith_pkg::t_cmd'(i_command);

    // Shift-add-3 stage: adjust every digit, then shift in the next value bit
    always_comb begin
        for (int i = 0; i < bcd_arith_pkg::DIGITS; i++) begin
            n_adj[4*i +: 4] = bcd_arith_pkg::dd_adjust(r_bcd[4*i +: 4]);
        end
        n_bcd = {n_adj[bcd_arith_pkg::BCD_W-2:0], r_bin[bcd_arith_pkg::VAL_W-1]};
    end

    // Multiplier step, top bit of the digit first: acc = 2*acc + (bit ? a : 0)
    assign n_mul = {r_bin[bcd_arith_pkg::VAL_W-2:0], 1'b0}
                 + (r_mul_b[3] ? bcd_arith_pkg::VAL_W'(r_opnd)
                               : {bcd_arith_pkg::VAL_W{1'b0}});

    // Sequencer, datapath registers and result beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_done       <= 1'b0;
            r_stored_bcd <= '0;
            r_stored_val <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd    <= n_cmd;
                        r_cnt    <= '0;
                        r_bcd    <= '0;
                        r_status <= 1'b0;
                        unique case (n_cmd)
                            bcd_arith_pkg::CMD_LOAD: begin
                                r_bin        <= bcd_arith_pkg::VAL_W'(i_operand_a);
                                r_stored_val <= i_operand_a;
                                r_state      <= S_CONV;
                            end
                            bcd_arith_pkg::CMD_SHOW: begin
                                r_res_bcd    <= bcd_arith_pkg::OUT_BCD_W'(r_stored_bcd);
                                r_res_val    <= bcd_arith_pkg::VAL_W'(r_stored_val);
                                r_res_status <= 1'b0;
                                r_done       <= 1'b1;
                            end
                            bcd_arith_pkg::CMD_ADD: begin
                                r_bin   <= bcd_arith_pkg::VAL_W'(i_operand_a)
                                         + bcd_arith_pkg::VAL_W'(i_operand_b);
                                r_state <= S_CONV;
                            end
                            bcd_arith_pkg::CMD_MUL: begin
                                r_bin   <= '0;
                                r_opnd  <= i_operand_a;
                                r_mul_b <= i_operand_b[3:0];
                                if (i_operand_b >
                                    bcd_arith_pkg::OPND_W'(bcd_arith_pkg::MAX_DIGIT)) begin
                                    // bad digit: convert zero, flag it
                                    r_status <= 1'b1;
                                    r_state  <= S_CONV;
                                end else begin
                                    r_state <= S_MUL;
                                end
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_MUL: begin
                    r_bin   <= n_mul;
                    r_mul_b <= {r_mul_b[2:0], 1'b0};
                    if (r_cnt == bcd_arith_pkg::CNT_W'(bcd_arith_pkg::MUL_STEPS - 1)) begin
                        r_cnt   <= '0;
                        r_state <= S_CONV;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_CONV: begin
                    // rotate so the value is back in place after the last pass
                    r_bcd <= n_bcd;
                    r_bin <= {r_bin[bcd_arith_pkg::VAL_W-2:0],
                              r_bin[bcd_arith_pkg::VAL_W-1]};
                    if (r_cnt == bcd_arith_pkg::CNT_W'(bcd_arith_pkg::VAL_W - 1)) begin
                        r_res_bcd    <= bcd_arith_pkg::OUT_BCD_W'(n_bcd);
                        r_res_val    <= {r_bin[bcd_arith_pkg::VAL_W-2:0],
                                         r_bin[bcd_arith_pkg::VAL_W-1]};
                        r_res_status <= r_status;
                        r_done       <= 1'b1;
                        if (r_cmd == bcd_arith_pkg::CMD_LOAD) begin
                            r_stored_bcd <= n_bcd;
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy           = (r_state != S_IDLE);
    assign o_done         = r_done;
    assign o_result_bcd   = r_res_bcd;
    assign o_result_value = r_res_val;
    assign o_status       = r_res_status;

    // A result beat only comes out once the sequencer is back at rest
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result beat while sequencer busy");

    // A flagged multiply returns zero digits and zero value
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status) |-> (o_result_bcd == '0 && o_result_value == '0))
        else $error("error result not zero");

    // Every accepted command other than show keeps the unit busy next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_command != bcd_arith_pkg::CMD_SHOW) |=> (busy && !o_done))
        else $error("command accepted but unit not busy");

endmodule

// ===== sim/bcd_digit_arithmetic_unit_tb.sv =====
// Self-checking testbench for the 16-digit BCD arithmetic unit: directed and
// random command beats, a digit-level predictor and an in-order result check.
// Depends on bcd_arith_pkg and bcd_digit_arithmetic_unit.
module bcd_digit_arithmetic_unit_tb;

    localparam logic [bcd_arith_pkg::OPND_W-1:0] OPND_MAX = '1;

    typedef struct {
        logic [bcd_arith_pkg::OUT_BCD_W-1:0] bcd;
        logic [bcd_arith_pkg::VAL_W-1:0]     value;
        logic                                status;
    } t_bcd_result;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic [1:0]                          i_command;
    logic [bcd_arith_pkg::OPND_W-1:0]    i_operand_a;
    logic [bcd_arith_pkg::OPND_W-1:0]    i_operand_b;
    logic                                o_done;
    logic [bcd_arith_pkg::OUT_BCD_W-1:0] o_result_bcd;
    logic [bcd_arith_pkg::VAL_W-1:0]     o_result_value;
    logic                                o_status;

    // Predictor state and the results still owed by the unit
    logic [bcd_arith_pkg::OUT_BCD_W-1:0] held_digits;
    t_bcd_result                         pending_results[$];
    t_bcd_result                         oldest_result;
    int                                  n_fail;
    int                                  idle_pct;

    bcd_digit_arithmetic_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_command      (i_command),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_done         (o_done),
        .o_result_bcd   (o_result_bcd),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Binary to packed BCD, keeping only DIGITS digits
    function automatic logic [bcd_arith_pkg::OUT_BCD_W-1:0] to_packed_bcd(
        input logic [63:0] v);
        logic [bcd_arith_pkg::OUT_BCD_W-1:0] r;
        r = '0;
        for (int i = 0; i < bcd_arith_pkg::DIGITS; i++) begin
            r[4*i +: 4] = 4'(v % 64'd10);
            v = v / 64'd10;
        end
        return r;
    endfunction

    // Binary value of packed digits; a nibble above nine reads as nine
    function automatic logic [bcd_arith_pkg::VAL_W-1:0] digits_to_value(
        input logic [bcd_arith_pkg::OUT_BCD_W-1:0] p);
        logic [63:0] v;
        logic [3:0]  nib;
        v = '0;
        for (int i = bcd_arith_pkg::DIGITS - 1; i >= 0; i--) begin
            nib = p[4*i +: 4];
            if (nib > 4'd9) nib = 4'd9;
            v = v * 64'd10 + 64'(nib);
        end
        return v[bcd_arith_pkg::VAL_W-1:0];
    endfunction

    // Clamp every nibble of the held number to a decimal digit
    function automatic logic [bcd_arith_pkg::OUT_BCD_W-1:0] clamp_digits(
        input logic [bcd_arith_pkg::OUT_BCD_W-1:0] p);
        logic [bcd_arith_pkg::OUT_BCD_W-1:0] r;
        r = '0;
        for (int i = 0; i < bcd_arith_pkg::DIGITS; i++)
            r[4*i +: 4] = (p[4*i +: 4] > 4'd9) ? 4'd9 : p[4*i +: 4];
        return r;
    endfunction

    // Expected result of one command beat; load updates the held number
    function automatic t_bcd_result predict_arith(
        input bcd_arith_pkg::t_cmd              cmd,
        input logic [bcd_arith_pkg::OPND_W-1:0] a,
        input logic [bcd_arith_pkg::OPND_W-1:0] b);
        t_bcd_result r;
        r.status = 1'b0;
        case (cmd)
            bcd_arith_pkg::CMD_LOAD: begin
                held_digits = to_packed_bcd(64'(a));
                r.bcd = held_digits;
            end
            bcd_arith_pkg::CMD_SHOW: r.bcd = clamp_digits(held_digits);
            bcd_arith_pkg::CMD_ADD:  r.bcd = to_packed_bcd(64'(a) + 64'(b));
            default: begin
                if (b > bcd_arith_pkg::OPND_W'(bcd_arith_pkg::MAX_DIGIT)) begin
                    r.bcd    = '0;
                    r.status = 1'b1;
                end else begin
                    r.bcd = to_packed_bcd(64'(a) * 64'(b));
                end
            end
        endcase
        r.value = digits_to_value(r.bcd);
        return r;
    endfunction

    // Result check: every o_done beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat: bcd %h value %0d status %0d",
                       o_result_bcd, o_result_value, o_status);
                n_fail++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_result_bcd !== oldest_result.bcd) begin
                    $error("result_bcd: expected %h, got %h", oldest_result.bcd, o_result_bcd);
                    n_fail++;
                end
                if (o_result_value !== oldest_result.value) begin
                    $error("result_value: expected %0d, got %0d",
                           oldest_result.value, o_result_value);
                    n_fail++;
                end
                if (o_status !== oldest_result.status) begin
                    $error("status: expected %0d, got %0d", oldest_result.status, o_status);
                    n_fail++;
                end
            end
        end
    end

    // Send one command beat, with a random idle gap first; start stays high after
    task automatic send_command(input bcd_arith_pkg::t_cmd              cmd,
                                input logic [bcd_arith_pkg::OPND_W-1:0] a,
                                input logic [bcd_arith_pkg::OPND_W-1:0] b);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start       <= 1'b1;
        i_command   <= cmd;
        i_operand_a <= a;
        i_operand_b <= b;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_arith(cmd, a, b));
    endtask

    // Hold the sender off until every owed result has come back
    task automatic wait_results_drained();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);
    endtask

    // Operands biased towards zero, full scale and long carry chains
    function automatic logic [bcd_arith_pkg::OPND_W-1:0] pick_operand();
        case ($urandom_range(7))
            0: return '0;
            1: return OPND_MAX;
            2: begin
                case ($urandom_range(4))
                    0: return bcd_arith_pkg::OPND_W'(9);
                    1: return bcd_arith_pkg::OPND_W'(99999);
                    2: return bcd_arith_pkg::OPND_W'(999999999);
                    3: return bcd_arith_pkg::OPND_W'(1999999999);
                    default: return bcd_arith_pkg::OPND_W'(1000000000);
                endcase
            end
            3: return bcd_arith_pkg::OPND_W'($urandom_range(99));
            default: return bcd_arith_pkg::OPND_W'($urandom);
        endcase
    endfunction

    // Multiplier: mostly a valid digit, sometimes just above nine or anything
    function automatic logic [bcd_arith_pkg::OPND_W-1:0] pick_multiplier();
        case ($urandom_range(9))
            0:       return bcd_arith_pkg::OPND_W'($urandom_range(15, 10));
            1, 2:    return bcd_arith_pkg::OPND_W'($urandom);
            default: return bcd_arith_pkg::OPND_W'(
                                $urandom_range(bcd_arith_pkg::MAX_DIGIT));
        endcase
    endfunction

    // Field extremes, every command and the special cases
    task automatic test_directed();
        send_command(bcd_arith_pkg::CMD_SHOW, '0, '0);
        send_command(bcd_arith_pkg::CMD_LOAD, '0, OPND_MAX);
        send_command(bcd_arith_pkg::CMD_SHOW, OPND_MAX, OPND_MAX);
        send_command(bcd_arith_pkg::CMD_LOAD, OPND_MAX, '0);
        send_command(bcd_arith_pkg::CMD_SHOW, '0, '0);
        send_command(bcd_arith_pkg::CMD_ADD, '0, '0);
        send_command(bcd_arith_pkg::CMD_ADD, OPND_MAX, OPND_MAX);
        send_command(bcd_arith_pkg::CMD_ADD, bcd_arith_pkg::OPND_W'(999999999),
                     bcd_arith_pkg::OPND_W'(1));
        send_command(bcd_arith_pkg::CMD_ADD, bcd_arith_pkg::OPND_W'(1999999999),
                     bcd_arith_pkg::OPND_W'(1));
        send_command(bcd_arith_pkg::CMD_ADD, bcd_arith_pkg::OPND_W'(5),
                     bcd_arith_pkg::OPND_W'(5));
        // add and multiply leave the held number alone
        send_command(bcd_arith_pkg::CMD_SHOW, '0, '0);
        send_command(bcd_arith_pkg::CMD_MUL, OPND_MAX, bcd_arith_pkg::OPND_W'(9));
        send_command(bcd_arith_pkg::CMD_MUL, '0, bcd_arith_pkg::OPND_W'(9));
        send_command(bcd_arith_pkg::CMD_MUL, OPND_MAX, '0);
        send_command(bcd_arith_pkg::CMD_MUL, bcd_arith_pkg::OPND_W'(999999999),
                     bcd_arith_pkg::OPND_W'(9));
        send_command(bcd_arith_pkg::CMD_MUL, bcd_arith_pkg::OPND_W'(123456789),
                     bcd_arith_pkg::OPND_W'(7));
        // multiplier digit above nine
        send_command(bcd_arith_pkg::CMD_MUL, OPND_MAX, bcd_arith_pkg::OPND_W'(10));
        send_command(bcd_arith_pkg::CMD_MUL, bcd_arith_pkg::OPND_W'(42),
                     bcd_arith_pkg::OPND_W'(15));
        send_command(bcd_arith_pkg::CMD_MUL, bcd_arith_pkg::OPND_W'(42), OPND_MAX);
        send_command(bcd_arith_pkg::CMD_SHOW, '0, '0);
        send_command(bcd_arith_pkg::CMD_LOAD, bcd_arith_pkg::OPND_W'(1234567890), '0);
        send_command(bcd_arith_pkg::CMD_SHOW, '0, '0);
    endtask

    // Random command mix at the current sender idle rate
    task automatic test_random(input int n_beats);
        int                               pick;
        bcd_arith_pkg::t_cmd              cmd;
        logic [bcd_arith_pkg::OPND_W-1:0] b;
        for (int n = 0; n < n_beats; n++) begin
            pick = $urandom_range(99);
            if (pick < 25)      cmd = bcd_arith_pkg::CMD_LOAD;
            else if (pick < 40) cmd = bcd_arith_pkg::CMD_SHOW;
            else if (pick < 70) cmd = bcd_arith_pkg::CMD_ADD;
            else                cmd = bcd_arith_pkg::CMD_MUL;
            b = (cmd == bcd_arith_pkg::CMD_MUL) ? pick_multiplier() : pick_operand();
            send_command(cmd, pick_operand(), b);
        end
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_command   = bcd_arith_pkg::CMD_LOAD;
        i_operand_a = '0;
        i_operand_b = '0;
        held_digits = '0;
        n_fail      = 0;
        idle_pct    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(640);
        wait_results_drained();
        idle_pct = 87;
        test_random(640);
        idle_pct = 30;
        test_random(640);

        // let the last result beat arrive
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (n_fail == 0 && pending_results.size() == 0)
            $display("bcd_digit_arithmetic_unit_tb: PASS");
        else
            $display("bcd_digit_arithmetic_unit_tb: FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("bcd_digit_arithmetic_unit_tb: FAIL");
        $finish;
    end

endmodule
